@@ rtl/core/buddy_page_allocator_core_defines.svh @@
// Assertion macros shared by the buddy page allocator RTL.
// Used inside modules that have clk and rst_n in scope.
`ifndef BUDDY_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buddy allocator assertion failed");

// Next-cycle implication, checked outside reset.
`define BPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buddy allocator assertion failed");

`endif

@@ rtl/core/bpa_pkg.sv @@
// Package for the buddy page allocator: sizes, codes, item structs and helpers.
// No dependencies.
package bpa_pkg;

  localparam int POOL_DEPTH  = 4096;
  localparam int ADDR_W      = 12;
  localparam int PAGE_W      = 13;
  localparam int ORDER_COUNT = 11;
  localparam int ORD_W       = 4;
  localparam int TOP_ORDER   = ORDER_COUNT - 1;
  localparam int MAX_BLOCK   = 1 << TOP_ORDER;

  localparam logic [ORD_W-1:0] NO_HEAD = 4'hF;

  // request codes
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_REBUILD = 2'd2;

  // status codes
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_BAD     = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [10:0]       page_count;
    logic [ADDR_W-1:0] page_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] block_index;
    logic [PAGE_W-1:0] free_total;
  } out_item_t;

  // pages in a block of order k
  function automatic logic [PAGE_W:0] pages_of(input logic [ORD_W-1:0] k);
    pages_of = (PAGE_W+1)'(1) << k;
  endfunction

  // smallest order whose block holds n pages (n up to MAX_BLOCK)
  function automatic logic [ORD_W-1:0] ceil_order(input logic [10:0] n);
    logic [ORD_W-1:0] r;
    r = ORD_W'(TOP_ORDER);
    for (int j = TOP_ORDER; j >= 0; j--) begin
      if ((PAGE_W+1)'(1 << j) >= (PAGE_W+1)'(n)) r = ORD_W'(j);
    end
    return r;
  endfunction

  // largest aligned order that starts at p and fits below size
  function automatic logic [ORD_W-1:0] carve_order(input logic [PAGE_W-1:0] p,
                                                   input logic [PAGE_W-1:0] size);
    logic [ORD_W-1:0] r;
    logic [PAGE_W:0]  sz;
    r = '0;
    for (int j = 0; j < ORDER_COUNT; j++) begin
      sz = (PAGE_W+1)'(1 << j);
      if ((((PAGE_W+1)'(p) & (sz - 1'b1)) == '0) &&
          ((PAGE_W+1)'(p) + sz <= (PAGE_W+1)'(size))) r = ORD_W'(j);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/bpa_head_ram.sv @@
// Single-port-write, single-port-read RAM with registered read data.
// Holds the free-block head order of each page. No dependencies.
module bpa_head_ram #(
  parameter int AW = 12,
  parameter int DW = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/bpa_engine.sv @@
// Request sequencer of the buddy allocator: scans, splits, merges and carves.
// Depends on bpa_pkg, bpa_head_ram and the shared assertion macros.
`include "buddy_page_allocator_core_defines.svh"
module bpa_engine
  import bpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  in_item_t          in_item,
  input  logic [PAGE_W-1:0] pool_pages,
  output logic              busy,
  output logic              out_valid,
  output out_item_t         out_item
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CLEAR  = 4'd1;
  localparam logic [3:0] ST_CARVE  = 4'd2;
  localparam logic [3:0] ST_ASCAN  = 4'd3;
  localparam logic [3:0] ST_ASPLIT = 4'd4;
  localparam logic [3:0] ST_FSCAN  = 4'd5;
  localparam logic [3:0] ST_FMRD   = 4'd6;
  localparam logic [3:0] ST_FMCHK  = 4'd7;
  localparam logic [3:0] ST_FPUT   = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [PAGE_W-1:0] p_r, p_nxt;
  logic [PAGE_W-1:0] size_r, size_nxt;
  logic [PAGE_W-1:0] tot_r, tot_nxt;
  logic [PAGE_W-1:0] cnt_r [ORDER_COUNT];
  logic [PAGE_W-1:0] cnt_nxt [ORDER_COUNT];
  logic [ORD_W-1:0]  k_r, k_nxt;
  logic [ORD_W-1:0]  want_r, want_nxt;
  logic [10:0]       n_r, n_nxt;
  logic [ADDR_W-1:0] b_r, b_nxt;
  logic [ADDR_W-1:0] at_r, at_nxt;
  logic [ADDR_W-1:0] bud_r, bud_nxt;
  logic [ADDR_W-1:0] q_addr_r, q_addr_nxt;
  logic              q_vld_r, q_vld_nxt;
  logic              emit_r, emit_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [ADDR_W-1:0] blk_r, blk_nxt;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [ORD_W-1:0]  wr_data, rd_data;

  // helpers for the request decode
  logic [10:0]       in_n;
  logic [ADDR_W-1:0] in_b;
  logic [ORD_W-1:0]  in_want, fit_k, ck, km;
  logic              fit_found, free_bad;
  logic [PAGE_W:0]   blk_end, req_end;
  logic [ADDR_W-1:0] bud;

  bpa_head_ram #(.AW(ADDR_W), .DW(ORD_W)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // decode terms for a new request
  always_comb begin
    in_n    = in_item.page_count;
    in_b    = in_item.page_index;
    in_want = ceil_order(in_n);
    fit_found = 1'b0;
    fit_k     = '0;
    for (int j = TOP_ORDER; j >= 0; j--) begin
      if (ORD_W'(j) >= in_want && cnt_r[j] != '0) begin
        fit_found = 1'b1;
        fit_k     = ORD_W'(j);
      end
    end
    free_bad = (in_n == '0) || ((in_n & (in_n - 1'b1)) != '0) ||
               (32'(in_n) > MAX_BLOCK) ||
               ((in_b & ADDR_W'(in_n - 1'b1)) != '0) ||
               ((PAGE_W'(in_b) + PAGE_W'(in_n)) > size_r);
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    p_nxt      = p_r;
    size_nxt   = size_r;
    tot_nxt    = tot_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    want_nxt   = want_r;
    n_nxt      = n_r;
    b_nxt      = b_r;
    at_nxt     = at_r;
    bud_nxt    = bud_r;
    q_addr_nxt = q_addr_r;
    q_vld_nxt  = 1'b0;
    emit_nxt   = emit_r;
    status_nxt = status_r;
    blk_nxt    = blk_r;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = NO_HEAD;
    rd_en      = 1'b0;
    rd_addr    = p_r[ADDR_W-1:0];
    ck         = carve_order(p_r, size_r);
    km         = k_r - 1'b1;
    bud        = b_r ^ ADDR_W'(pages_of(k_r));
    blk_end    = (PAGE_W+1)'(q_addr_r) + pages_of(rd_data);
    req_end    = (PAGE_W+1)'(b_r) + (PAGE_W+1)'(n_r);

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt      = in_n;
          b_nxt      = in_b;
          p_nxt      = '0;
          emit_nxt   = 1'b1;
          blk_nxt    = '0;
          status_nxt = STAT_DONE;
          unique case (in_item.req_type)
            REQ_ALLOC: begin
              if (in_n == '0 || 32'(in_n) > MAX_BLOCK) begin
                status_nxt = STAT_BAD;
                state_nxt  = ST_DONE;
              end else if (!fit_found) begin
                status_nxt = STAT_NOSPACE;
                state_nxt  = ST_DONE;
              end else begin
                k_nxt     = fit_k;
                want_nxt  = in_want;
                state_nxt = ST_ASCAN;
              end
            end
            REQ_FREE: begin
              if (free_bad) begin
                status_nxt = STAT_BAD;
                state_nxt  = ST_DONE;
              end else begin
                k_nxt     = in_want;
                state_nxt = ST_FSCAN;
              end
            end
            REQ_REBUILD: begin
              size_nxt = (32'(pool_pages) > POOL_DEPTH) ? PAGE_W'(POOL_DEPTH) : pool_pages;
              tot_nxt  = '0;
              for (int j = 0; j < ORDER_COUNT; j++) cnt_nxt[j] = '0;
              state_nxt = ST_CLEAR;
            end
            default: begin
              status_nxt = STAT_BAD;
              state_nxt  = ST_DONE;
            end
          endcase
        end
      end
      // wipe every head entry
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = p_r[ADDR_W-1:0];
        if (32'(p_r) == POOL_DEPTH - 1) begin
          p_nxt     = '0;
          state_nxt = ST_CARVE;
        end else begin
          p_nxt = p_r + 1'b1;
        end
      end
      // one maximal aligned block per cycle
      ST_CARVE: begin
        if (p_r >= size_r) begin
          state_nxt = ST_DONE;
        end else begin
          wr_en       = 1'b1;
          wr_addr     = p_r[ADDR_W-1:0];
          wr_data     = ck;
          cnt_nxt[ck] = cnt_r[ck] + 1'b1;
          tot_nxt     = tot_r + PAGE_W'(pages_of(ck));
          p_nxt       = p_r + PAGE_W'(pages_of(ck));
        end
      end
      // pipelined scan for the lowest head of order k
      ST_ASCAN: begin
        if (p_r < size_r) begin
          rd_en      = 1'b1;
          q_vld_nxt  = 1'b1;
          q_addr_nxt = p_r[ADDR_W-1:0];
          p_nxt      = p_r + 1'b1;
        end
        if (q_vld_r && rd_data == k_r) begin
          wr_en        = 1'b1;
          wr_addr      = q_addr_r;
          cnt_nxt[k_r] = cnt_r[k_r] - 1'b1;
          tot_nxt      = tot_r - PAGE_W'(pages_of(k_r));
          at_nxt       = q_addr_r;
          if (k_r == want_r) begin
            blk_nxt   = q_addr_r;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_ASPLIT;
          end
        end
      end
      // free the upper half, keep the lower
      ST_ASPLIT: begin
        wr_en       = 1'b1;
        wr_addr     = at_r + ADDR_W'(pages_of(km));
        wr_data     = km;
        cnt_nxt[km] = cnt_r[km] + 1'b1;
        tot_nxt     = tot_r + PAGE_W'(pages_of(km));
        k_nxt       = km;
        if (km == want_r) begin
          blk_nxt   = at_r;
          state_nxt = ST_DONE;
        end
      end
      // overlap check against every free block
      ST_FSCAN: begin
        if (p_r < size_r) begin
          rd_en      = 1'b1;
          q_vld_nxt  = 1'b1;
          q_addr_nxt = p_r[ADDR_W-1:0];
          p_nxt      = p_r + 1'b1;
        end
        if (q_vld_r && 32'(rd_data) < ORDER_COUNT &&
            (PAGE_W+1)'(q_addr_r) < req_end && (PAGE_W+1)'(b_r) < blk_end) begin
          status_nxt = STAT_BAD;
          state_nxt  = ST_DONE;
        end else if (!q_vld_r && p_r >= size_r) begin
          state_nxt = ST_FMRD;
        end
      end
      // fetch the buddy of the current block
      ST_FMRD: begin
        if (32'(k_r) == TOP_ORDER || PAGE_W'(bud) >= size_r) begin
          state_nxt = ST_FPUT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = bud;
          bud_nxt   = bud;
          state_nxt = ST_FMCHK;
        end
      end
      // merge when the buddy is free at the same order
      ST_FMCHK: begin
        if (rd_data == k_r) begin
          wr_en        = 1'b1;
          wr_addr      = bud_r;
          cnt_nxt[k_r] = cnt_r[k_r] - 1'b1;
          tot_nxt      = tot_r - PAGE_W'(pages_of(k_r));
          if (bud_r < b_r) b_nxt = bud_r;
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_FMRD;
        end else begin
          state_nxt = ST_FPUT;
        end
      end
      ST_FPUT: begin
        wr_en        = 1'b1;
        wr_addr      = b_r;
        wr_data      = k_r;
        cnt_nxt[k_r] = cnt_r[k_r] + 1'b1;
        tot_nxt      = tot_r + PAGE_W'(pages_of(k_r));
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and bookkeeping registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      p_r     <= '0;
      size_r  <= PAGE_W'(POOL_DEPTH);
      tot_r   <= '0;
      for (int j = 0; j < ORDER_COUNT; j++) cnt_r[j] <= '0;
      q_vld_r <= 1'b0;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_r     <= p_nxt;
      size_r  <= size_nxt;
      tot_r   <= tot_nxt;
      cnt_r   <= cnt_nxt;
      q_vld_r <= q_vld_nxt;
      emit_r  <= emit_nxt;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    want_r   <= want_nxt;
    n_r      <= n_nxt;
    b_r      <= b_nxt;
    at_r     <= at_nxt;
    bud_r    <= bud_nxt;
    q_addr_r <= q_addr_nxt;
    status_r <= status_nxt;
    blk_r    <= blk_nxt;
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = (state_r == ST_DONE) && emit_r;
  assign out_item.status      = status_r;
  assign out_item.block_index = (status_r == STAT_DONE) ? blk_r : '0;
  assign out_item.free_total  = tot_r;

  `BPA_ASSERT_NXT(a_start_leaves_idle, start && !busy, busy)
  `BPA_ASSERT_NXT(a_result_then_idle, out_valid, !busy)
  `BPA_ASSERT_IMP(a_total_bounded, 1'b1, 32'(tot_r) <= POOL_DEPTH)

endmodule

@@ rtl/core/buddy_page_allocator_core.sv @@
// Top level of the buddy page allocator: config register port and the engine.
// Depends on bpa_pkg and bpa_engine.
//
//  channel  | ports                              | handshake
//  ---------+------------------------------------+---------------------------------
//  request  | start, busy, in_item               | taken when start && !busy
//  result   | out_valid, out_item                | one-cycle strobe, never stalled
//  config   | psel penable pwrite paddr pwdata.. | psel&penable&pwrite, paddr[2] low
//
// One item at a time; the strobe comes in the last busy cycle, then it goes idle.
// Alloc: find the first head of the chosen order, split it to the wanted order.
// Free: scan the pool for overlap, then read and check the buddy per merged order,
// then write the final head. Rebuild: clear every head entry, then carve the pool
// one maximal aligned block at a time. Early rejects go straight to the result.
// After reset the block rebuilds a 4096-page pool (busy high, no result).
module buddy_page_allocator_core
  import bpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [PAGE_W-1:0] pool_pages_r, pool_pages_nxt;
  logic              cfg_wr;

  // register write; bit 2 selects past the only register
  assign cfg_wr         = psel && penable && pwrite && !paddr[2];
  assign pool_pages_nxt = cfg_wr ? pwdata[PAGE_W-1:0] : pool_pages_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_pages_r <= PAGE_W'(POOL_DEPTH);
    end else begin
      pool_pages_r <= pool_pages_nxt;
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : {{(32-PAGE_W){1'b0}}, pool_pages_r};

  bpa_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .pool_pages (pool_pages_r),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

endmodule
